[hdl/stbs_pkg.sv]
// Shared definitions for the sorted table search core.
// Holds field widths, operation codes and the controller/datapath link structs.
// No dependencies.
`default_nettype none

package stbs_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;

  localparam int LEN_W   = 11;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [POS_W-1:0] POS_NONE = '1;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic load_hit;
    logic load_miss;
  } cmd_t;

  typedef struct packed {
    logic live_start;
    logic live_step;
    logic hit;
  } status_t;

endpackage

`default_nettype wire

[hdl/stbs_datapath.sv]
// Datapath of the sorted table search core: table memory, bounds, probe and result word.
// Driven by stbs_ctrl through stbs_pkg::cmd_t, reports through stbs_pkg::status_t.
`default_nettype none

module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [stbs_pkg::LEN_W-1:0]     cfg_length,
  input  wire logic [stbs_pkg::INDEX_W-1:0]   entry_index,
  input  wire logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  wire stbs_pkg::cmd_t                 cmd,
  output stbs_pkg::status_t                   status,
  output logic                                found,
  output logic signed [stbs_pkg::POS_W-1:0]   position
);
  import stbs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int LW     = (CW > LEN_W) ? CW : LEN_W;
  localparam int IW     = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int AW2    = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  logic [VALUE_W-1:0]        mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] key;
  logic [LEN_W-1:0]          list_length;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [ADDR_W-1:0]         mid;

  logic [CW-1:0]     used;
  logic [CW-1:0]     lo_step, hi_step;
  logic [CW-1:0]     lo_next, hi_next;
  logic [CW:0]       mid_sum;
  logic [ADDR_W-1:0] mid_next;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;
  logic              key_lt;
  logic              rd_en;

  assign used = (LW'(list_length) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(list_length);

  assign key_lt  = key < rd_data;
  assign lo_step = key_lt ? lo : (CW'(mid) + CW'(1));
  assign hi_step = key_lt ? CW'(mid) : hi;

  always_comb begin
    if (cmd.start) begin
      lo_next = '0;
      hi_next = used;
    end else if (cmd.step) begin
      lo_next = lo_step;
      hi_next = hi_step;
    end else begin
      lo_next = lo;
      hi_next = hi;
    end
  end

  assign mid_sum  = {1'b0, lo_next} + {1'b0, hi_next} - (CW+1)'(1);
  assign mid_next = ADDR_W'(mid_sum >> 1);

  assign status.live_start = used != '0;
  assign status.live_step  = lo_step < hi_step;
  assign status.hit        = rd_data == key;

  assign rd_en   = (cmd.start && status.live_start) || (cmd.step && status.live_step);
  assign wr_ok   = IW'(entry_index) < IW'(TABLE_DEPTH);
  assign wr_addr = ADDR_W'(AW2'(entry_index));

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[mid_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
    end else if (cfg_we) begin
      list_length <= cfg_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= value;
    end
    if (cmd.start || cmd.step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
    if (cmd.load_hit) begin
      found    <= 1'b1;
      position <= POS_W'(mid);
    end else if (cmd.load_miss) begin
      found    <= 1'b0;
      position <= POS_NONE;
    end
  end

endmodule

`default_nettype wire

[hdl/stbs_ctrl.sv]
// Controller of the sorted table search core: handshakes and probe sequencing.
// Uses stbs_pkg for operation codes and the datapath link structs.
`default_nettype none

module stbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire stbs_pkg::status_t status,
  output stbs_pkg::cmd_t         cmd
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_MISS
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation == OP_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = status.live_start ? S_SEARCH : S_MISS;
          end
        end
      end
      S_SEARCH: begin
        if (status.hit) begin
          if (out_free) begin
            cmd.load_hit = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (!status.live_step) begin
          if (out_free) begin
            cmd.load_miss = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_MISS: begin
        if (out_free) begin
          cmd.load_miss = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = (cmd.load_hit || cmd.load_miss) ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_load_when_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(cmd.load_hit || cmd.load_miss))
    else $error("result loaded over a held word");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.write, cmd.start, cmd.step, cmd.load_hit, cmd.load_miss}))
    else $error("conflicting datapath commands");

  a_hit_only_on_match: assert property (@(posedge clk) disable iff (rst)
    cmd.load_hit |-> (status.hit && state == S_SEARCH))
    else $error("hit reported without a matching probe");

  a_ready_after_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_hit || cmd.load_miss) |=> (!in_stall && out_valid))
    else $error("controller not idle with result after load");

endmodule

`default_nettype wire

[hdl/sorted_table_binary_search_core.sv]
// Sorted table binary search core: a search of the first list_length entries, capped at
// TABLE_DEPTH, makes at most floor(log2(n))+1 probes for n searched entries; each probe
// is one read of the single-port table memory, whose registered output is compared and
// used to pick the next midpoint in the same cycle. A write word gives no result and
// leaves the core idle. A finished result is held in the output register while the next
// word is accepted. The table memory has no reset; searches must touch only entries that
// were written. list_length is taken on the config channel; it is for the user to write
// it only while the core is idle, as the core has no check for it.
// Top level: ties stbs_ctrl and stbs_datapath together; uses stbs_pkg.
`default_nettype none

module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [stbs_pkg::LEN_W-1:0]          list_length,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                operation,
  input  wire logic [stbs_pkg::INDEX_W-1:0]        entry_index,
  input  wire logic signed [stbs_pkg::VALUE_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     found,
  output logic signed [stbs_pkg::POS_W-1:0]        position
);
  import stbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_length  (list_length),
    .entry_index (entry_index),
    .value       (value),
    .cmd         (cmd),
    .status      (status),
    .found       (found),
    .position    (position)
  );

endmodule

`default_nettype wire
